@@ hdl/dvrt_pkg.sv @@
// dvrt_pkg: shared constants, codes and controller/datapath interface types
// for the distance-vector route table; no dependencies
package dvrt_pkg;

	localparam int TABLE_ENTRIES  = 32;
	localparam int ADVERT_ENTRIES = 32;
	localparam int TBL_IW = $clog2(TABLE_ENTRIES);
	localparam int ADV_IW = $clog2(ADVERT_ENTRIES);
	localparam int ADV_CW = $clog2(ADVERT_ENTRIES + 1);

	localparam logic [2:0] CMD_ADVERT = 3'd0;
	localparam logic [2:0] CMD_LINK   = 3'd1;
	localparam logic [2:0] CMD_EXPIRE = 3'd2;
	localparam logic [2:0] CMD_DUMP   = 3'd3;
	localparam logic [2:0] CMD_LOOKUP = 3'd4;

	localparam logic [1:0] REG_OWN_ID   = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_INFINITY = 2'd2;

	localparam logic [15:0] OWN_ID_RESET   = 16'd0;
	localparam logic [31:0] TIMEOUT_RESET  = 32'(45 * 1000);
	localparam logic [15:0] INFINITY_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DISPATCH, ST_SELF, ST_FIND, ST_APPLY, ST_MSEL, ST_SWEEP, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {AP_SENDER, AP_MERGE, AP_LINKNEW, AP_LOOKUP} apply_op_t;

	typedef enum logic [1:0] {TS_NODE, TS_SENDER, TS_BUF} tgt_sel_t;

	typedef struct packed {
		logic      latch;
		logic      buf_write;
		logic      cnt_clr;
		logic      k_clr;
		logic      k_inc;
		logic      jump_load;
		logic      find_start;
		tgt_sel_t  tgt_sel;
		logic      find_step;
		logic      apply;
		apply_op_t ap_op;
		logic      sweep_start;
		logic      sweep_step;
		logic      emit;
		logic      emit_lookup;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       link_new;
		logic       elast;
		logic       k_done;
		logic       buf_is_self;
		logic       i_last;
		logic       valid_i;
		logic       any_valid;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ hdl/dvrt_ctrl.sv @@
// dvrt_ctrl: command sequencer for the route table
// depends on dvrt_pkg; drives dvrt_dp through dp_cmd_t, reads dp_stat_t
module dvrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dvrt_pkg::dp_stat_t stat,
	output dvrt_pkg::dp_cmd_t  ctl
);

	dvrt_pkg::state_t    state_q, state_d;
	dvrt_pkg::apply_op_t ap_q, ap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvrt_pkg::ST_IDLE;
			ap_q    <= dvrt_pkg::AP_SENDER;
		end else begin
			state_q <= state_d;
			ap_q    <= ap_d;
		end
	end

	// dump entries need the output slot before the step may go ahead
	logic dump_hold;
	assign dump_hold = (stat.cmd == dvrt_pkg::CMD_DUMP) && stat.valid_i && !stat.out_free;

	// next state
	always_comb begin
		state_d = state_q;
		ap_d    = ap_q;
		case (state_q)
			dvrt_pkg::ST_IDLE: begin
				if (in_valid) state_d = dvrt_pkg::ST_DISPATCH;
			end
			dvrt_pkg::ST_DISPATCH: begin
				ap_d = dvrt_pkg::AP_SENDER;
				case (stat.cmd)
					dvrt_pkg::CMD_ADVERT: begin
						state_d = stat.elast ? dvrt_pkg::ST_SELF : dvrt_pkg::ST_EMIT;
					end
					dvrt_pkg::CMD_LINK: begin
						if (stat.link_new) begin
							ap_d    = dvrt_pkg::AP_LINKNEW;
							state_d = dvrt_pkg::ST_FIND;
						end else begin
							state_d = dvrt_pkg::ST_SWEEP;
						end
					end
					dvrt_pkg::CMD_EXPIRE, dvrt_pkg::CMD_DUMP: state_d = dvrt_pkg::ST_SWEEP;
					dvrt_pkg::CMD_LOOKUP: begin
						ap_d    = dvrt_pkg::AP_LOOKUP;
						state_d = dvrt_pkg::ST_FIND;
					end
					default: state_d = dvrt_pkg::ST_EMIT;
				endcase
			end
			dvrt_pkg::ST_SELF: begin
				if (stat.k_done) begin
					state_d = dvrt_pkg::ST_EMIT;
				end else if (stat.buf_is_self) begin
					ap_d    = dvrt_pkg::AP_SENDER;
					state_d = dvrt_pkg::ST_FIND;
				end
			end
			dvrt_pkg::ST_FIND: begin
				if (stat.i_last)
					state_d = (ap_q == dvrt_pkg::AP_LOOKUP) ? dvrt_pkg::ST_EMIT
						: dvrt_pkg::ST_APPLY;
			end
			dvrt_pkg::ST_APPLY: begin
				if (ap_q == dvrt_pkg::AP_SENDER || ap_q == dvrt_pkg::AP_MERGE)
					state_d = dvrt_pkg::ST_MSEL;
				else
					state_d = dvrt_pkg::ST_EMIT;
			end
			dvrt_pkg::ST_MSEL: begin
				if (stat.k_done) begin
					state_d = dvrt_pkg::ST_EMIT;
				end else if (!stat.buf_is_self) begin
					ap_d    = dvrt_pkg::AP_MERGE;
					state_d = dvrt_pkg::ST_FIND;
				end
			end
			dvrt_pkg::ST_SWEEP: begin
				if (!dump_hold && stat.i_last) begin
					if (stat.cmd == dvrt_pkg::CMD_DUMP && stat.any_valid)
						state_d = dvrt_pkg::ST_IDLE;
					else
						state_d = dvrt_pkg::ST_EMIT;
				end
			end
			dvrt_pkg::ST_EMIT: begin
				if (stat.out_free) state_d = dvrt_pkg::ST_IDLE;
			end
			default: state_d = dvrt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		ctl.ap_op   = ap_q;
		ctl.tgt_sel = dvrt_pkg::TS_NODE;
		case (state_q)
			dvrt_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				ctl.latch = in_valid;
			end
			dvrt_pkg::ST_DISPATCH: begin
				case (stat.cmd)
					dvrt_pkg::CMD_ADVERT: begin
						ctl.buf_write = 1'b1;
						ctl.k_clr     = stat.elast;
					end
					dvrt_pkg::CMD_LINK: begin
						ctl.find_start  = stat.link_new;
						ctl.sweep_start = !stat.link_new;
					end
					dvrt_pkg::CMD_EXPIRE, dvrt_pkg::CMD_DUMP: ctl.sweep_start = 1'b1;
					dvrt_pkg::CMD_LOOKUP: ctl.find_start = 1'b1;
					default: ;
				endcase
			end
			dvrt_pkg::ST_SELF: begin
				if (stat.k_done) begin
					ctl.cnt_clr = 1'b1;
				end else if (stat.buf_is_self) begin
					ctl.jump_load  = 1'b1;
					ctl.find_start = 1'b1;
					ctl.tgt_sel    = dvrt_pkg::TS_SENDER;
				end else begin
					ctl.k_inc = 1'b1;
				end
			end
			dvrt_pkg::ST_FIND: ctl.find_step = 1'b1;
			dvrt_pkg::ST_APPLY: begin
				ctl.apply = 1'b1;
				ctl.k_clr = (ap_q == dvrt_pkg::AP_SENDER);
				ctl.k_inc = (ap_q == dvrt_pkg::AP_MERGE);
			end
			dvrt_pkg::ST_MSEL: begin
				if (stat.k_done) begin
					ctl.cnt_clr = 1'b1;
				end else if (stat.buf_is_self) begin
					ctl.k_inc = 1'b1;
				end else begin
					ctl.find_start = 1'b1;
					ctl.tgt_sel    = dvrt_pkg::TS_BUF;
				end
			end
			dvrt_pkg::ST_SWEEP: ctl.sweep_step = !dump_hold;
			dvrt_pkg::ST_EMIT: begin
				ctl.emit        = stat.out_free;
				ctl.emit_lookup = (ap_q == dvrt_pkg::AP_LOOKUP);
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/dvrt_dp.sv @@
// dvrt_dp: route table, advertisement buffer, config registers and output register
// depends on dvrt_pkg; sequenced by dvrt_ctrl
module dvrt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  dvrt_pkg::dp_cmd_t  ctl,
	output dvrt_pkg::dp_stat_t stat,
	input  logic [2:0]         cmd,
	input  logic [15:0]        node_id,
	input  logic [15:0]        sender_id,
	input  logic [15:0]        cost_value,
	input  logic [15:0]        old_link_cost,
	input  logic               link_is_new,
	input  logic               entry_last,
	input  logic [31:0]        now_ms,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        dest_id,
	output logic [15:0]        next_hop,
	output logic [15:0]        route_cost,
	output logic               entry_found,
	output logic               table_changed,
	output logic               last
);

	localparam int T  = dvrt_pkg::TABLE_ENTRIES;
	localparam int A  = dvrt_pkg::ADVERT_ENTRIES;
	localparam int IW = dvrt_pkg::TBL_IW;
	localparam int KW = dvrt_pkg::ADV_IW;
	localparam int CW = dvrt_pkg::ADV_CW;

	// latched transaction
	logic [2:0]  cmd_q;
	logic [15:0] node_q, snd_in_q, cost_q, oldc_q;
	logic        new_q, elast_q;
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q    <= cmd;
			node_q   <= node_id;
			snd_in_q <= sender_id;
			cost_q   <= cost_value;
			oldc_q   <= old_link_cost;
			new_q    <= link_is_new;
			elast_q  <= entry_last;
			now_q    <= now_ms;
		end
	end

	// config registers
	logic [15:0] own_q, inf_q;
	logic [31:0] tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= dvrt_pkg::OWN_ID_RESET;
			tmo_q <= dvrt_pkg::TIMEOUT_RESET;
			inf_q <= dvrt_pkg::INFINITY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				dvrt_pkg::REG_OWN_ID:   own_q <= cfg_data[15:0];
				dvrt_pkg::REG_TIMEOUT:  tmo_q <= cfg_data;
				dvrt_pkg::REG_INFINITY: inf_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// advertisement buffer
	logic [15:0]   buf_node [A];
	logic [15:0]   buf_cost [A];
	logic [CW-1:0] cnt_q, k_q;
	logic [15:0]   sender_q;
	logic [KW-1:0] kidx;
	logic [15:0]   k_node, k_cost;

	assign kidx   = k_q[KW-1:0];
	assign k_node = buf_node[kidx];
	assign k_cost = buf_cost[kidx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sender_q <= '0;
			k_q      <= '0;
		end else begin
			if (ctl.buf_write) begin
				if (cnt_q == '0) sender_q <= snd_in_q;
				if (cnt_q < CW'(A)) cnt_q <= cnt_q + 1'b1;
			end else if (ctl.cnt_clr) begin
				cnt_q <= '0;
			end
			if (ctl.k_clr) k_q <= '0;
			else if (ctl.k_inc) k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.buf_write && cnt_q < CW'(A)) begin
			buf_node[cnt_q[KW-1:0]] <= node_q;
			buf_cost[cnt_q[KW-1:0]] <= cost_q;
		end
	end

	// hop cost and merge operands
	logic [15:0] jump_q, tgt_q, adv_q, sum_q;
	logic [16:0] raw_sum;

	assign raw_sum = {1'b0, jump_q} + {1'b0, k_cost};

	always_ff @(posedge clk) begin
		if (ctl.jump_load) jump_q <= k_cost;
		if (ctl.find_start) begin
			case (ctl.tgt_sel)
				dvrt_pkg::TS_SENDER: tgt_q <= sender_q;
				dvrt_pkg::TS_BUF: begin
					tgt_q <= k_node;
					adv_q <= k_cost;
					sum_q <= (raw_sum > {1'b0, inf_q}) ? inf_q : raw_sum[15:0];
				end
				default: tgt_q <= node_q;
			endcase
		end
	end

	// route table
	logic [T-1:0] valid_q;
	logic [15:0]  r_dest [T];
	logic [15:0]  r_nh   [T];
	logic [15:0]  r_cost [T];
	logic [31:0]  r_time [T];

	logic [IW-1:0] i_q;
	logic          e_valid;
	logic [15:0]   e_dest, e_nh, e_cost;
	logic [31:0]   e_time;

	assign e_valid = valid_q[i_q];
	assign e_dest  = r_dest[i_q];
	assign e_nh    = r_nh[i_q];
	assign e_cost  = r_cost[i_q];
	assign e_time  = r_time[i_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) i_q <= '0;
		else if (ctl.find_start || ctl.sweep_start) i_q <= '0;
		else if (ctl.find_step || ctl.sweep_step) i_q <= i_q + 1'b1;
	end

	// first match and first free slot of a scan
	logic          m_found_q, f_found_q;
	logic [IW-1:0] m_idx_q, f_idx_q;
	logic [15:0]   m_nh_q, m_cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else if (ctl.find_start) begin
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else if (ctl.find_step) begin
			if (e_valid && e_dest == tgt_q && !m_found_q) m_found_q <= 1'b1;
			if (!e_valid && !f_found_q) f_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.find_step) begin
			if (e_valid && e_dest == tgt_q && !m_found_q) begin
				m_idx_q  <= i_q;
				m_nh_q   <= e_nh;
				m_cost_q <= e_cost;
			end
			if (!e_valid && !f_found_q) f_idx_q <= i_q;
		end
	end

	// entry update
	logic          u_valid_we, u_valid_val, u_dest_we, u_nh_we, u_cost_we, u_time_we;
	logic [IW-1:0] u_idx;
	logic [15:0]   u_dest, u_nh, u_cost;
	logic          set_chg;
	logic signed [17:0] rs;
	logic [15:0]   rc;
	logic [31:0]   age;

	assign rs  = $signed({2'b0, e_cost}) - $signed({2'b0, oldc_q}) + $signed({2'b0, cost_q});
	assign age = now_q - e_time;

	always_comb begin
		u_valid_we  = 1'b0;
		u_valid_val = 1'b0;
		u_dest_we   = 1'b0;
		u_nh_we     = 1'b0;
		u_cost_we   = 1'b0;
		u_time_we   = 1'b0;
		u_idx       = i_q;
		u_dest      = tgt_q;
		u_nh        = '0;
		u_cost      = '0;
		set_chg     = 1'b0;
		rc          = e_cost;
		if (ctl.apply) begin
			if (!m_found_q) begin
				// new route into the first free slot
				u_idx       = f_idx_q;
				u_valid_val = 1'b1;
				case (ctl.ap_op)
					dvrt_pkg::AP_SENDER: begin
						u_nh   = sender_q;
						u_cost = jump_q;
						u_valid_we = f_found_q;
					end
					dvrt_pkg::AP_MERGE: begin
						u_nh   = sender_q;
						u_cost = sum_q;
						u_valid_we = f_found_q && (adv_q != inf_q);
					end
					dvrt_pkg::AP_LINKNEW: begin
						u_nh   = node_q;
						u_cost = cost_q;
						u_valid_we = f_found_q;
					end
					default: ;
				endcase
				u_dest_we = u_valid_we;
				u_nh_we   = u_valid_we;
				u_cost_we = u_valid_we;
				u_time_we = u_valid_we;
				set_chg   = u_valid_we;
			end else begin
				u_idx = m_idx_q;
				case (ctl.ap_op)
					dvrt_pkg::AP_SENDER: begin
						u_time_we = 1'b1;
						u_cost    = jump_q;
						if (m_cost_q != jump_q) begin
							u_cost_we = 1'b1;
							set_chg   = 1'b1;
						end
					end
					dvrt_pkg::AP_MERGE: begin
						u_nh   = sender_q;
						u_cost = sum_q;
						if (m_nh_q == sender_q) begin
							set_chg = 1'b1;
							if (adv_q == inf_q) begin
								u_valid_we = 1'b1;
							end else begin
								u_cost_we = 1'b1;
								u_time_we = 1'b1;
							end
						end else if (adv_q != inf_q && sum_q <= m_cost_q) begin
							u_nh_we   = 1'b1;
							u_cost_we = 1'b1;
							u_time_we = 1'b1;
							set_chg   = 1'b1;
						end
					end
					dvrt_pkg::AP_LINKNEW: begin
						u_nh   = node_q;
						u_cost = cost_q;
						if (m_cost_q > cost_q) begin
							u_nh_we   = 1'b1;
							u_cost_we = 1'b1;
							u_time_we = 1'b1;
							set_chg   = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end else if (ctl.sweep_step && e_valid) begin
			case (cmd_q)
				dvrt_pkg::CMD_LINK: begin
					if (e_nh == node_q && cost_q == inf_q) begin
						u_valid_we = 1'b1;
						set_chg    = 1'b1;
					end else begin
						if (e_nh == node_q) begin
							if (rs < 0) rc = '0;
							else if (rs > $signed({2'b0, inf_q})) rc = inf_q;
							else rc = rs[15:0];
							u_cost_we = 1'b1;
							u_time_we = 1'b1;
							set_chg   = 1'b1;
						end
						if (e_dest == node_q && rc > cost_q) begin
							rc        = cost_q;
							u_nh      = node_q;
							u_nh_we   = 1'b1;
							u_cost_we = 1'b1;
							u_time_we = 1'b1;
							set_chg   = 1'b1;
						end
						u_cost = rc;
					end
				end
				dvrt_pkg::CMD_EXPIRE: begin
					if (age > tmo_q) begin
						u_valid_we = 1'b1;
						set_chg    = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (u_valid_we) valid_q[u_idx] <= u_valid_val;
	end

	always_ff @(posedge clk) begin
		if (u_dest_we) r_dest[u_idx] <= u_dest;
		if (u_nh_we)   r_nh[u_idx]   <= u_nh;
		if (u_cost_we) r_cost[u_idx] <= u_cost;
		if (u_time_we) r_time[u_idx] <= now_q;
	end

	logic chg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chg_q <= 1'b0;
		else if (ctl.latch) chg_q <= 1'b0;
		else if (set_chg) chg_q <= 1'b1;
	end

	// output register
	logic         out_valid_q, out_free, dump_load;
	logic [T-1:0] vsh;

	assign out_free  = !out_valid_q || out_ready;
	assign dump_load = ctl.sweep_step && (cmd_q == dvrt_pkg::CMD_DUMP) && e_valid;
	assign vsh       = valid_q >> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ctl.emit || dump_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dump_load) begin
			dest_id       <= e_dest;
			next_hop      <= e_nh;
			// poison reverse toward the dumped neighbor
			route_cost    <= (e_nh == node_q && e_dest != e_nh) ? inf_q : e_cost;
			entry_found   <= 1'b1;
			table_changed <= 1'b0;
			last          <= (vsh[T-1:1] == '0);
		end else if (ctl.emit) begin
			if (ctl.emit_lookup) begin
				dest_id     <= tgt_q;
				next_hop    <= m_found_q ? m_nh_q : 16'd0;
				route_cost  <= m_found_q ? m_cost_q : inf_q;
				entry_found <= m_found_q;
			end else begin
				dest_id     <= '0;
				next_hop    <= '0;
				route_cost  <= '0;
				entry_found <= 1'b0;
			end
			table_changed <= ctl.emit_lookup ? 1'b0 : chg_q;
			last          <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.cmd         = cmd_q;
	assign stat.link_new    = new_q;
	assign stat.elast       = elast_q;
	assign stat.k_done      = (k_q >= cnt_q);
	assign stat.buf_is_self = (k_node == own_q);
	assign stat.i_last      = (i_q == IW'(T - 1));
	assign stat.valid_i     = e_valid;
	assign stat.any_valid   = |valid_q;
	assign stat.out_free    = out_free;

endmodule

@@ hdl/distance_vector_route_table_top.sv @@
// distance_vector_route_table_top: top level of the route table block
// depends on dvrt_pkg, dvrt_ctrl and dvrt_dp
//
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   cmd node_id sender_id cost_value old_link_cost
//                                      link_is_new entry_last now_ms
// out       out  out_valid / out_ready dest_id next_hop route_cost entry_found
//                                      table_changed last
// cfg       in   cfg_valid / cfg_ready cfg_index cfg_data
//
// one transaction at a time; T = table entries, A = buffered advert entries
// advert entry without last: buffered, then a result; unknown cmd: result only
// lookup, new link: one table scan; expiry, rescale, dump: one table sweep
// advert with last: a buffer walk for the own id, then one table scan for the sender
// and one per other entry; the scan counter walks the single table read port
// reset clears valid bits, counters and config; no clearing pass is needed
// a finished result waits in the output register while the next transaction
// is taken; each result waits for the previous one to leave on out_ready
module distance_vector_route_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] node_id,
	input  logic [15:0] sender_id,
	input  logic [15:0] cost_value,
	input  logic [15:0] old_link_cost,
	input  logic        link_is_new,
	input  logic        entry_last,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] dest_id,
	output logic [15:0] next_hop,
	output logic [15:0] route_cost,
	output logic        entry_found,
	output logic        table_changed,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	dvrt_pkg::dp_cmd_t  ctl;
	dvrt_pkg::dp_stat_t stat;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer: walks scans and merge steps, owns the in handshake
	dvrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath: table, advert buffer, config, output register
	dvrt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.node_id       (node_id),
		.sender_id     (sender_id),
		.cost_value    (cost_value),
		.old_link_cost (old_link_cost),
		.link_is_new   (link_is_new),
		.entry_last    (entry_last),
		.now_ms        (now_ms),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.dest_id       (dest_id),
		.next_hop      (next_hop),
		.route_cost    (route_cost),
		.entry_found   (entry_found),
		.table_changed (table_changed),
		.last          (last)
	);

endmodule

@@ hdl/dvrt_checker.sv @@
// dvrt_checker: port-level assertions for the route table top
// depends only on the top level's ports; bound below
module dvrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] next_hop,
	input logic        entry_found,
	input logic        table_changed,
	input logic        last
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one transaction in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// only dump routes are not last, and those always report a route
	a_dump_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> entry_found && !table_changed)
		else $error("non-final result without route");

	// a result with no route carries no next hop
	a_miss_hop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_found |-> next_hop == 16'd0)
		else $error("next hop on empty result");

endmodule

bind distance_vector_route_table_top dvrt_checker u_dvrt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.next_hop      (next_hop),
	.entry_found   (entry_found),
	.table_changed (table_changed),
	.last          (last)
);

@@ tb/distance_vector_route_table_top_tb.sv @@
`timescale 1ns / 100ps
// distance_vector_route_table_top_tb: self-checking bench for the route table block
// depends on dvrt_pkg and distance_vector_route_table_top; keeps its own table model
module distance_vector_route_table_top_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [15:0] node_id;
	logic [15:0] sender_id;
	logic [15:0] cost_value;
	logic [15:0] old_link_cost;
	logic        link_is_new;
	logic        entry_last;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] dest_id;
	logic [15:0] next_hop;
	logic [15:0] route_cost;
	logic        entry_found;
	logic        table_changed;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	distance_vector_route_table_top dut (.*);

	typedef struct {
		logic [15:0] dest;
		logic [15:0] hop;
		logic [15:0] cost;
		logic        found;
		logic        changed;
		logic        lst;
	} route_report_t;

	// model state
	logic [15:0] m_own_id;
	logic [31:0] m_timeout;
	logic [15:0] m_inf;
	logic        rt_valid [dvrt_pkg::TABLE_ENTRIES];
	logic [15:0] rt_dest  [dvrt_pkg::TABLE_ENTRIES];
	logic [15:0] rt_hop   [dvrt_pkg::TABLE_ENTRIES];
	logic [15:0] rt_cost  [dvrt_pkg::TABLE_ENTRIES];
	logic [31:0] rt_stamp [dvrt_pkg::TABLE_ENTRIES];
	logic [15:0] adv_node [dvrt_pkg::ADVERT_ENTRIES];
	logic [15:0] adv_cost [dvrt_pkg::ADVERT_ENTRIES];
	int          adv_cnt;
	logic [15:0] adv_sender;

	route_report_t expected_routes[$];
	int mismatches;
	int results_seen;
	int items_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;
	bit timed_out;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------- prediction
	function automatic int route_slot(input logic [15:0] d);
		for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
			if (rt_valid[i] && rt_dest[i] == d)
				return i;
		return -1;
	endfunction

	function automatic bit route_insert(input logic [15:0] d, input logic [15:0] h,
			input logic [15:0] c, input logic [31:0] t);
		for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
			if (!rt_valid[i]) begin
				rt_valid[i] = 1'b1;
				rt_dest[i] = d;
				rt_hop[i] = h;
				rt_cost[i] = c;
				rt_stamp[i] = t;
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic bit merge_advert(input logic [31:0] t);
		bit chg;
		bit have;
		logic [15:0] jump;
		logic [15:0] snd;
		logic [16:0] sum;
		logic [15:0] s16;
		int r;
		chg = 0;
		have = 0;
		jump = '0;
		snd = adv_sender;
		for (int k = 0; k < adv_cnt; k++)
			if (!have && adv_node[k] == m_own_id) begin
				jump = adv_cost[k];
				have = 1;
			end
		if (!have)
			return 1'b0;
		r = route_slot(snd);
		if (r < 0) begin
			if (route_insert(snd, snd, jump, t))
				chg = 1;
		end else begin
			if (rt_cost[r] != jump) begin
				rt_cost[r] = jump;
				chg = 1;
			end
			rt_stamp[r] = t;
		end
		for (int k = 0; k < adv_cnt; k++) begin
			if (adv_node[k] == m_own_id)
				continue;
			sum = {1'b0, jump} + {1'b0, adv_cost[k]};
			s16 = (sum > {1'b0, m_inf}) ? m_inf : sum[15:0];
			r = route_slot(adv_node[k]);
			if (r < 0) begin
				if (adv_cost[k] != m_inf && route_insert(adv_node[k], snd, s16, t))
					chg = 1;
			end else if (rt_hop[r] == snd) begin
				if (adv_cost[k] == m_inf)
					rt_valid[r] = 1'b0;
				else begin
					rt_cost[r] = s16;
					rt_stamp[r] = t;
				end
				chg = 1;
			end else if (adv_cost[k] != m_inf && s16 <= rt_cost[r]) begin
				rt_hop[r] = snd;
				rt_cost[r] = s16;
				rt_stamp[r] = t;
				chg = 1;
			end
		end
		return chg;
	endfunction

	function automatic bit link_update(input logic [15:0] nei, input logic [15:0] oldc,
			input logic [15:0] newc, input logic is_new, input logic [31:0] t);
		bit chg;
		int r;
		longint c;
		chg = 0;
		if (is_new) begin
			r = route_slot(nei);
			if (r < 0) begin
				if (route_insert(nei, nei, newc, t))
					chg = 1;
			end else if (rt_cost[r] > newc) begin
				rt_cost[r] = newc;
				rt_hop[r] = nei;
				rt_stamp[r] = t;
				chg = 1;
			end
			return chg;
		end
		for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++) begin
			if (!rt_valid[i])
				continue;
			if (rt_hop[i] == nei) begin
				if (newc == m_inf) begin
					rt_valid[i] = 1'b0;
					chg = 1;
					continue;
				end
				c = longint'(rt_cost[i]) - longint'(oldc) + longint'(newc);
				if (c < 0)
					c = 0;
				if (c > longint'(m_inf))
					c = longint'(m_inf);
				rt_cost[i] = c[15:0];
				rt_stamp[i] = t;
				chg = 1;
			end
			if (rt_dest[i] == nei && rt_cost[i] > newc) begin
				rt_cost[i] = newc;
				rt_hop[i] = nei;
				rt_stamp[i] = t;
				chg = 1;
			end
		end
		return chg;
	endfunction

	function automatic void push_route(input logic [15:0] d, input logic [15:0] h,
			input logic [15:0] c, input logic f, input logic ch, input logic l);
		route_report_t e;
		e.dest = d;
		e.hop = h;
		e.cost = c;
		e.found = f;
		e.changed = ch;
		e.lst = l;
		expected_routes = {expected_routes, e};
	endfunction

	function automatic void predict_routes(input logic [2:0] c, input logic [15:0] nd,
			input logic [15:0] sd, input logic [15:0] cv, input logic [15:0] oc,
			input logic ln, input logic el, input logic [31:0] t);
		bit chg;
		int n;
		int r;
		logic [15:0] pc;
		chg = 0;
		case (c)
			dvrt_pkg::CMD_ADVERT: begin
				if (adv_cnt == 0)
					adv_sender = sd;
				if (adv_cnt < dvrt_pkg::ADVERT_ENTRIES) begin
					adv_node[adv_cnt] = nd;
					adv_cost[adv_cnt] = cv;
					adv_cnt++;
				end
				if (el) begin
					chg = merge_advert(t);
					adv_cnt = 0;
				end
				push_route(0, 0, 0, 0, chg, 1);
			end
			dvrt_pkg::CMD_LINK: begin
				chg = link_update(nd, oc, cv, ln, t);
				push_route(0, 0, 0, 0, chg, 1);
			end
			dvrt_pkg::CMD_EXPIRE: begin
				for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
					if (rt_valid[i] && (t - rt_stamp[i]) > m_timeout) begin
						rt_valid[i] = 1'b0;
						chg = 1;
					end
				push_route(0, 0, 0, 0, chg, 1);
			end
			dvrt_pkg::CMD_DUMP: begin
				n = 0;
				for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
					if (rt_valid[i]) begin
						// poison reverse toward the neighbor the dump is for
						pc = (rt_hop[i] == nd && rt_dest[i] != rt_hop[i]) ? m_inf : rt_cost[i];
						push_route(rt_dest[i], rt_hop[i], pc, 1, 0, 0);
						n++;
					end
				if (n == 0)
					push_route(0, 0, 0, 0, 0, 1);
				else
					expected_routes[$].lst = 1'b1;
			end
			dvrt_pkg::CMD_LOOKUP: begin
				r = route_slot(nd);
				if (r < 0)
					push_route(nd, 0, m_inf, 0, 0, 1);
				else
					push_route(rt_dest[r], rt_hop[r], rt_cost[r], 1, 0, 1);
			end
			default: push_route(0, 0, 0, 0, 0, 1);
		endcase
	endfunction

	// ------------------------------------------------------------- driving
	// valid stays up after a transaction until the next item or an idle cycle
	task automatic send_item(input logic [2:0] c, input logic [15:0] nd,
			input logic [15:0] sd, input logic [15:0] cv, input logic [15:0] oc,
			input logic ln, input logic el, input logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		node_id <= nd;
		sender_id <= sd;
		cost_value <= cv;
		old_link_cost <= oc;
		link_is_new <= ln;
		entry_last <= el;
		now_ms <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_routes(c, nd, sd, cv, oc, ln, el, t);
		items_sent++;
		@(negedge clk);
	endtask

	// waits until every expected result has come, then lets the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_routes.size() != 0 && !timed_out)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			dvrt_pkg::REG_OWN_ID:   m_own_id = val[15:0];
			dvrt_pkg::REG_TIMEOUT:  m_timeout = val;
			dvrt_pkg::REG_INFINITY: m_inf = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------- checking
	always @(posedge clk) begin
		route_report_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_routes.size() == 0) begin
				report_mismatch("unexpected result", 32'd1, 32'd0);
			end else begin
				e = expected_routes.pop_front();
				if (dest_id !== e.dest)
					report_mismatch("dest_id", dest_id, e.dest);
				if (next_hop !== e.hop)
					report_mismatch("next_hop", next_hop, e.hop);
				if (route_cost !== e.cost)
					report_mismatch("route_cost", route_cost, e.cost);
				if (entry_found !== e.found)
					report_mismatch("entry_found", entry_found, e.found);
				if (table_changed !== e.changed)
					report_mismatch("table_changed", table_changed, e.changed);
				if (last !== e.lst)
					report_mismatch("last", last, e.lst);
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("distance_vector_route_table_top: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------- tests
	// small id space so that adverts, links and lookups hit the same routes
	function automatic logic [15:0] pick_node();
		return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
	endfunction

	task automatic send_advert(input logic [15:0] snd, input logic [31:0] t, input int n);
		int self_at;
		logic [15:0] cv;
		self_at = ($urandom_range(7) == 0) ? -1 : $urandom_range(n - 1);
		for (int k = 0; k < n; k++) begin
			cv = ($urandom_range(5) == 0) ? m_inf : 16'($urandom_range(40));
			if ($urandom_range(15) == 0)
				cv = 16'($urandom);
			send_item(dvrt_pkg::CMD_ADVERT, (k == self_at) ? m_own_id : pick_node(),
				(k == 0) ? snd : 16'($urandom), cv, 16'($urandom), $urandom_range(1),
				k == n - 1, t);
		end
	endtask

	task automatic test_directed();
		// empty dump, lookup miss, empty expiry, unknown codes
		send_item(dvrt_pkg::CMD_DUMP, 16'd0, 0, 0, 0, 0, 0, 0);
		send_item(dvrt_pkg::CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1,
			32'hFFFF_FFFF);
		send_item(dvrt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		for (int c = 5; c < 8; c++)
			send_item(3'(c), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 32'hFFFF_FFFF);
		// new links, then a new link to a known neighbor at a lower cost
		send_item(dvrt_pkg::CMD_LINK, 16'd3, 0, 16'd5, 0, 1, 0, 100);
		send_item(dvrt_pkg::CMD_LINK, 16'd4, 0, 16'hFFF0, 0, 1, 0, 100);
		send_item(dvrt_pkg::CMD_LINK, 16'd3, 0, 16'd2, 0, 1, 0, 110);
		// advert with a saturating sum, two self entries, an infinite entry
		send_item(dvrt_pkg::CMD_ADVERT, 16'd7, 16'd4, 16'd100, 0, 0, 0, 120);
		send_item(dvrt_pkg::CMD_ADVERT, m_own_id, 16'd9, 16'd1, 0, 0, 0, 120);
		send_item(dvrt_pkg::CMD_ADVERT, m_own_id, 16'd9, 16'd9, 0, 0, 0, 120);
		send_item(dvrt_pkg::CMD_ADVERT, 16'd8, 16'd9, 16'hFFFF, 0, 0, 1, 120);
		// advert without a self entry is ignored
		send_item(dvrt_pkg::CMD_ADVERT, 16'd9, 16'd5, 16'd1, 0, 0, 1, 130);
		send_item(dvrt_pkg::CMD_DUMP, 16'd4, 0, 0, 0, 0, 0, 140);
		send_item(dvrt_pkg::CMD_LINK, 16'd4, 0, 16'd1, 16'hFFFF, 0, 0, 150);
		send_item(dvrt_pkg::CMD_LINK, 16'd3, 0, 16'hFFFF, 16'd1, 0, 0, 150);
		send_item(dvrt_pkg::CMD_LOOKUP, 16'd4, 0, 0, 0, 0, 0, 160);
		send_item(dvrt_pkg::CMD_LOOKUP, 16'd7, 0, 0, 0, 0, 0, 160);
		// expiry at the modulo wrap of the clock
		send_item(dvrt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 32'd45160);
		send_item(dvrt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFF0);
		send_item(dvrt_pkg::CMD_DUMP, 16'd4, 0, 0, 0, 0, 0, 170);
	endtask

	// overfill both the advert buffer and the table
	task automatic test_overflow();
		for (int k = 0; k < dvrt_pkg::ADVERT_ENTRIES + 3; k++)
			send_item(dvrt_pkg::CMD_ADVERT, (k == 1) ? m_own_id : 16'(100 + k), 16'd50,
				16'd1, 0, 0, k == dvrt_pkg::ADVERT_ENTRIES + 2, 200);
		for (int k = 0; k < 4; k++)
			send_item(dvrt_pkg::CMD_LINK, 16'(300 + k), 0, 16'd3, 0, 1, 0, 210);
		send_item(dvrt_pkg::CMD_DUMP, 16'd50, 0, 0, 0, 0, 0, 220);
		send_item(dvrt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
	endtask

	task automatic test_random(input int n_items);
		logic [31:0] t;
		int start;
		int pick;
		t = $urandom_range(1000);
		start = items_sent;
		while (items_sent - start < n_items) begin
			t += $urandom_range(8000);
			pick = $urandom_range(99);
			if (pick < 40)
				send_advert(pick_node(), t, $urandom_range(1, 5));
			else if (pick < 55)
				send_item(dvrt_pkg::CMD_LINK, pick_node(), 0,
					($urandom_range(5) == 0) ? m_inf : 16'($urandom_range(30)),
					16'($urandom_range(30)), $urandom_range(1), $urandom_range(1), t);
			else if (pick < 65)
				send_item(dvrt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0,
					($urandom_range(9) == 0) ? $urandom : t);
			else if (pick < 77)
				send_item(dvrt_pkg::CMD_DUMP, pick_node(), 16'($urandom), 0, 0, 0, 0, t);
			else if (pick < 94)
				send_item(dvrt_pkg::CMD_LOOKUP, pick_node(), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom_range(1), $urandom_range(1), t);
			else
				// noise: random fields and codes, including unknown ones
				send_item(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom_range(1), $urandom_range(1), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = '0;
		node_id = '0;
		sender_id = '0;
		cost_value = '0;
		old_link_cost = '0;
		link_is_new = 1'b0;
		entry_last = 1'b0;
		now_ms = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_own_id = dvrt_pkg::OWN_ID_RESET;
		m_timeout = dvrt_pkg::TIMEOUT_RESET;
		m_inf = dvrt_pkg::INFINITY_RESET;
		for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
			rt_valid[i] = 1'b0;
		adv_cnt = 0;
		adv_sender = '0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		quiet_cycles = 0;
		timed_out = 0;
		send_idle_pct = 34;
		recv_idle_pct = 61;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings first
		test_directed();
		test_random(70);

		// extreme settings: top own id, zero timeout, infinity of one
		write_reg(dvrt_pkg::REG_OWN_ID, 32'h0000_FFFF);
		write_reg(dvrt_pkg::REG_TIMEOUT, 32'd0);
		write_reg(dvrt_pkg::REG_INFINITY, 32'd1);
		test_random(40);

		send_idle_pct = 61;
		recv_idle_pct = 34;
		write_reg(dvrt_pkg::REG_OWN_ID, 32'd5);
		write_reg(dvrt_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(dvrt_pkg::REG_INFINITY, 32'd25);
		test_overflow();
		test_random(120);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(dvrt_pkg::REG_OWN_ID, 32'd0);
		write_reg(dvrt_pkg::REG_TIMEOUT, 32'd20000);
		write_reg(dvrt_pkg::REG_INFINITY, 32'hFFFF);
		test_random(150);

		drain();
		$display("run covered %0d input items and %0d results over four register settings,",
			items_sent, results_seen);
		$display("with directed edge cases, buffer and table overflow, and random traffic");
		if (mismatches == 0 && expected_routes.size() == 0)
			$display("distance_vector_route_table_top: match");
		else
			$display("distance_vector_route_table_top: mismatch");
		$finish;
	end
endmodule
